// ----- rtl/core/hbt_pkg.sv -----
// Package for the hex bitmap table: sizes, request codes and the
// command and status groups between the controller and the datapath.
// Used by every module of the block; depends on nothing.
package hbt_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int KEY_CHARS   = 16;
   localparam int FIELD_COUNT = 128;
   localparam int REQ_DATA_W  = 152;
   localparam int RSP_DATA_W  = 136;
   localparam logic [127:0] ASCII_ZEROS = {16{8'h30}};

   typedef enum logic [2:0] {
      OP_INSERT = 3'd0,
      OP_FIND   = 3'd1,
      OP_READ   = 3'd2,
      OP_SET    = 3'd3,
      OP_CLEAR  = 3'd4,
      OP_TEST   = 3'd5
   } hbt_op_type;

   typedef struct packed {
      logic load_req;
      logic scan_start;
      logic scan_step;
      logic acc_rd;
      logic insert;
      logic fld_wr;
      logic ok_wr;
      logic ok_val;
      logic rsp_load;
   } hbt_cmd_type;

   typedef struct packed {
      hbt_op_type op;
      logic       len_ok;
      logic       idx_ok;
      logic       fnum_ok;
      logic       full;
      logic       scan_hit;
      logic       scan_done;
      logic       fld_ok;
   } hbt_sts_type;

endpackage

// ----- rtl/core/hbt_ctrl.sv -----
// Controller state machine of the hex bitmap table.
// Depends on hbt_pkg; drives the datapath hbt_dp through command signals.
module hbt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  hbt_pkg::hbt_sts_type sts,
   output hbt_pkg::hbt_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_ACC_RD,
      ST_ACC_MOD,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load_req = req_tvalid;
         end
         ST_CHECK: begin
            case (sts.op)
               hbt_pkg::OP_INSERT: begin
                  if (sts.len_ok && !sts.full) begin
                     cmd.scan_start = 1'b1;
                  end else begin
                     cmd.ok_wr = 1'b1;
                  end
               end
               hbt_pkg::OP_FIND: begin
                  if (sts.len_ok) begin
                     cmd.scan_start = 1'b1;
                  end else begin
                     cmd.ok_wr = 1'b1;
                  end
               end
               hbt_pkg::OP_READ: begin
                  cmd.ok_wr = !(sts.len_ok && sts.idx_ok);
               end
               hbt_pkg::OP_SET, hbt_pkg::OP_CLEAR, hbt_pkg::OP_TEST: begin
                  cmd.ok_wr = !(sts.idx_ok && sts.fnum_ok);
               end
               default: begin
                  cmd.ok_wr = 1'b1;
               end
            endcase
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_hit) begin
               cmd.ok_wr  = 1'b1;
               cmd.ok_val = (sts.op == hbt_pkg::OP_FIND);
            end else if (sts.scan_done) begin
               cmd.ok_wr  = 1'b1;
               cmd.insert = (sts.op == hbt_pkg::OP_INSERT);
               cmd.ok_val = (sts.op == hbt_pkg::OP_INSERT);
            end
         end
         ST_ACC_RD: begin
            cmd.acc_rd = 1'b1;
         end
         ST_ACC_MOD: begin
            cmd.ok_wr  = 1'b1;
            cmd.ok_val = (sts.op == hbt_pkg::OP_READ) ? 1'b1 : sts.fld_ok;
            cmd.fld_wr = (sts.op != hbt_pkg::OP_READ);
         end
         ST_FINISH: begin
            cmd.rsp_load = slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (cmd.scan_start) begin
                  state_ff <= ST_SCAN;
               end else if (cmd.ok_wr) begin
                  state_ff <= ST_FINISH;
               end else begin
                  state_ff <= ST_ACC_RD;
               end
            end
            ST_SCAN: begin
               if (sts.scan_hit || sts.scan_done) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_ACC_RD: begin
               state_ff <= ST_ACC_MOD;
            end
            ST_ACC_MOD: begin
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (slot_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   a_rsp_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("Result loaded while the output register is still occupied.");

   a_insert_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> (sts.scan_done && !sts.scan_hit && !sts.full))
      else $error("Insert issued without a finished miss on a table with room.");

   a_field_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.fld_wr |-> (sts.idx_ok && sts.fnum_ok))
      else $error("Field write issued for a bad entry or field number.");

endmodule

// ----- rtl/core/hbt_dp.sv -----
// Datapath of the hex bitmap table: request registers, the primary and
// secondary map memories, the search pointer and the field logic.
// Depends on hbt_pkg; controlled by hbt_ctrl.
module hbt_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  hbt_pkg::hbt_cmd_type                cmd,
   output hbt_pkg::hbt_sts_type                sts,
   input  logic [2:0]                          req_tuser,
   input  logic [hbt_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic [hbt_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int IDX_W = hbt_pkg::IDX_W;
   localparam int CNT_W = hbt_pkg::CNT_W;

   logic [2:0]       op_ff;
   logic [63:0]      key_hi_ff;
   logic [63:0]      key_lo_ff;
   logic [7:0]       len_ff;
   logic [7:0]       idx_ff;
   logic [7:0]       fnum_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] issue_ff;
   logic             pend_ff;
   logic             ok_ff;

   logic [127:0] prim_mem [hbt_pkg::MAX_ENTRIES];
   logic [127:0] sec_mem  [hbt_pkg::MAX_ENTRIES];
   logic         sec_vld_ff [hbt_pkg::MAX_ENTRIES];
   logic [127:0] prim_rd_ff;
   logic [127:0] sec_rd_ff;
   logic         sec_vld_rd_ff;

   logic         rsp_success_ff;
   logic [127:0] rsp_data_ff;
   logic [4:0]   rsp_count_ff;

   hbt_pkg::hbt_op_type op;
   logic             issue_lt;
   logic             prim_rd_en;
   logic [IDX_W-1:0] prim_ra;
   logic [IDX_W-1:0] acc_idx;
   logic             prim_we;
   logic [IDX_W-1:0] prim_wa;
   logic [127:0]     prim_wd;
   logic             sec_we;
   logic [6:0]       fld;
   logic             sec_sel;
   logic [3:0]       pos_sh;
   logic [3:0]       mask;
   logic [127:0]     word;
   logic [7:0]       ch;
   logic             hex_ok;
   logic [3:0]       hv;
   logic [3:0]       nv;
   logic [7:0]       nch;
   logic [127:0]     new_word;
   logic             fld_we;
   logic             fld_ok;

   assign op       = hbt_pkg::hbt_op_type'(op_ff);
   assign acc_idx  = idx_ff[IDX_W-1:0];
   assign issue_lt = (issue_ff < count_ff);

   assign sts.op        = op;
   assign sts.len_ok    = (len_ff >= 8'(hbt_pkg::KEY_CHARS));
   assign sts.idx_ok    = (32'(idx_ff) < 32'(count_ff));
   assign sts.fnum_ok   = (fnum_ff != 8'd0) && (fnum_ff <= 8'(hbt_pkg::FIELD_COUNT));
   assign sts.full      = (count_ff == CNT_W'(hbt_pkg::MAX_ENTRIES));
   assign sts.scan_hit  = pend_ff && (prim_rd_ff == {key_hi_ff, key_lo_ff});
   assign sts.scan_done = !pend_ff && !issue_lt;
   assign sts.fld_ok    = fld_ok;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff     <= req_tuser;
         key_hi_ff <= req_tdata[63:0];
         key_lo_ff <= req_tdata[127:64];
         len_ff    <= req_tdata[135:128];
         idx_ff    <= req_tdata[143:136];
         fnum_ff   <= req_tdata[151:144];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         issue_ff <= '0;
         pend_ff  <= 1'b0;
         ok_ff    <= 1'b0;
      end else begin
         if (cmd.insert) begin
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.scan_start) begin
            issue_ff <= '0;
            pend_ff  <= 1'b0;
         end else if (cmd.scan_step) begin
            pend_ff <= issue_lt;
            if (issue_lt) begin
               issue_ff <= issue_ff + 1'b1;
            end
         end
         if (cmd.ok_wr) begin
            ok_ff <= cmd.ok_val;
         end
      end
   end

   // Field n sits in character (n-1)/4 of the map, bit 3-((n-1)%4).
   always_comb begin
      fld     = 7'(fnum_ff - 8'd1);
      sec_sel = fld[6];
      pos_sh  = ~fld[5:2];
      mask    = 4'b1000 >> fld[1:0];
      if (sec_sel) begin
         word = sec_vld_rd_ff ? sec_rd_ff : hbt_pkg::ASCII_ZEROS;
      end else begin
         word = prim_rd_ff;
      end
      ch     = word[{pos_sh, 3'b000} +: 8];
      hex_ok = 1'b0;
      hv     = 4'd0;
      if (ch inside {[8'h30:8'h39]}) begin
         hex_ok = 1'b1;
         hv     = ch[3:0];
      end else if (ch inside {[8'h41:8'h46]}) begin
         hex_ok = 1'b1;
         hv     = 4'(ch[3:0] + 4'd9);
      end
      nv  = (op == hbt_pkg::OP_SET) ? (hv | mask) : (hv & ~mask);
      nch = (nv < 4'd10) ? {4'h3, nv} : {4'h4, 4'(nv - 4'd9)};
      for (int b = 0; b < 16; b++) begin
         new_word[b*8 +: 8] = (4'(b) == pos_sh) ? nch : word[b*8 +: 8];
      end
      fld_we = hex_ok && ((op == hbt_pkg::OP_SET) || (op == hbt_pkg::OP_CLEAR));
      fld_ok = hex_ok && ((op == hbt_pkg::OP_TEST) ? |(hv & mask) : 1'b1);
   end

   always_comb begin
      prim_rd_en = (cmd.scan_step && issue_lt) || cmd.acc_rd;
      prim_ra    = cmd.scan_step ? issue_ff[IDX_W-1:0] : acc_idx;
      prim_we    = cmd.insert || (cmd.fld_wr && fld_we && !sec_sel);
      prim_wa    = cmd.insert ? count_ff[IDX_W-1:0] : acc_idx;
      prim_wd    = cmd.insert ? {key_hi_ff, key_lo_ff} : new_word;
      sec_we     = cmd.fld_wr && fld_we && sec_sel;
   end

   always_ff @(posedge clock) begin
      if (prim_we) begin
         prim_mem[prim_wa] <= prim_wd;
      end
      if (prim_rd_en) begin
         prim_rd_ff <= prim_mem[prim_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (sec_we) begin
         sec_mem[acc_idx] <= new_word;
      end
      if (cmd.acc_rd) begin
         sec_rd_ff     <= sec_mem[acc_idx];
         sec_vld_rd_ff <= sec_vld_ff[acc_idx];
      end
   end

   // An unwritten secondary entry reads as all ASCII zeros.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < hbt_pkg::MAX_ENTRIES; i++) begin
            sec_vld_ff[i] <= 1'b0;
         end
      end else if (sec_we) begin
         sec_vld_ff[acc_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_success_ff <= ok_ff;
         rsp_data_ff    <= ((op == hbt_pkg::OP_READ) && ok_ff) ? prim_rd_ff : '0;
         rsp_count_ff   <= 5'(count_ff);
      end
   end

   assign rsp_tdata = {2'b00, rsp_count_ff, rsp_data_ff[63:0], rsp_data_ff[127:64],
                       rsp_success_ff};

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(hbt_pkg::MAX_ENTRIES))
      else $error("Entry count beyond table size.");

   a_count_inc: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> (count_ff == CNT_W'($past(count_ff) + 1'b1)))
      else $error("Insert did not add exactly one entry.");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.insert |=> $stable(count_ff))
      else $error("Entry count changed without an insert.");

endmodule

// ----- rtl/core/hex_bitmap_table.sv -----
// Hex bitmap table: a table of up to 16 ISO 8583 bitmaps held as ASCII hex
// characters, with a secondary map per entry, and insert, find, read and
// field set, clear and test requests. Each request gives one result. Insert
// and find search the stored entries one per cycle through the primary map
// memory's read port; a hit ends the search early. Read and the field
// requests make one memory read, and set and clear then write the changed
// character back. A request that fails its checks goes straight to its
// result. A new request is taken while the previous result waits in the
// output register. Built from hbt_ctrl and hbt_dp; uses hbt_pkg.
module hex_bitmap_table (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // req_tuser: req_type[2:0]
   input  logic [2:0]                     req_tuser,
   // req_tdata: key_hi[63:0], key_lo[127:64], key_len[135:128],
   // entry_index[143:136], field_number[151:144]
   input  logic [hbt_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // rsp_tdata: success[0], data_hi[64:1], data_lo[128:65],
   // entry_count[133:129], zero[135:134]
   output logic [hbt_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   hbt_pkg::hbt_cmd_type cmd;
   hbt_pkg::hbt_sts_type sts;

   hbt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   hbt_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule
